@@ sv/tspg_pkg.sv @@
// Shared types, register codes and the quarter-wave table function of the pattern generator.
`default_nettype none
package tspg_pkg;

    typedef enum logic [1:0] {
        MODE_IMPULSE = 2'd0,
        MODE_PULSE   = 2'd1,
        MODE_SINE    = 2'd2,
        MODE_ONES    = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        REG_MODE   = 3'd0,
        REG_TOTAL  = 3'd1,
        REG_PERIOD = 3'd2,
        REG_PULSE  = 3'd3,
        REG_STEP   = 3'd4
    } reg_index_t;

    localparam int unsigned CFG_INDEX_BITS = 3;
    localparam int unsigned CFG_DATA_BITS  = 32;
    localparam int unsigned TOTAL_BITS     = 32;
    localparam int unsigned LEN_BITS       = 24;
    localparam int unsigned STEP_BITS      = 32;
    localparam int unsigned SAMPLE_BITS    = 16;
    localparam int unsigned MAG_BITS       = 15;
    localparam logic [MAG_BITS-1:0] FULL_SCALE = 15'd32767;

    typedef struct packed {
        mode_t                 mode;
        logic [TOTAL_BITS-1:0] total;
        logic [LEN_BITS-1:0]   period;
        logic [LEN_BITS-1:0]   pulse;
        logic [STEP_BITS-1:0]  step;
    } cfg_t;

    // Sample request handed from the counter stage to the output stage
    typedef struct packed {
        logic valid;
        logic sine;
        logic level;
        logic last;
    } req_t;

    // sin(pi/2 * k / 2^qbits) in Q30 by a Horner series, scaled to Q1.15
    function automatic logic [MAG_BITS-1:0] quarter_value(input int unsigned k,
                                                         input int unsigned qbits);
        logic [63:0] one;
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] v;
        logic [63:0] s;
        logic [63:0] r;
        one = 64'd1 << 30;
        t   = (64'd1686629713 * 64'(k)) >> qbits;
        t2  = (t * t) >> 30;
        v   = one;
        v   = one - (((t2 * v) >> 30) / 64'd156);
        v   = one - (((t2 * v) >> 30) / 64'd110);
        v   = one - (((t2 * v) >> 30) / 64'd72);
        v   = one - (((t2 * v) >> 30) / 64'd42);
        v   = one - (((t2 * v) >> 30) / 64'd20);
        v   = one - (((t2 * v) >> 30) / 64'd6);
        s   = (t * v) >> 30;
        r   = (s * 64'd32767 + (one >> 1)) >> 30;
        if (r > 64'd32767)
        begin
            r = 64'd32767;
        end
        return r[MAG_BITS-1:0];
    endfunction

endpackage
`default_nettype wire

@@ sv/tspg_sine.sv @@
// Quarter-wave sine lookup: table index to signed Q1.15 sample.
`default_nettype none
module tspg_sine #(
    parameter int unsigned TABLE_BITS = 10
) (
    input  wire logic [TABLE_BITS-1:0]              idx,
    output logic signed [tspg_pkg::SAMPLE_BITS-1:0] sample
);
    localparam int unsigned QBITS = TABLE_BITS - 2;
    localparam int unsigned N     = 1 << QBITS;

    logic [tspg_pkg::MAG_BITS-1:0] rom [0:N];
    logic [1:0]                    quad;
    logic [QBITS-1:0]              offset;
    logic [QBITS:0]                addr;
    logic [tspg_pkg::MAG_BITS-1:0] mag;

    for (genvar k = 0; k <= N; k++)
    begin : g_rom
        assign rom[k] = tspg_pkg::quarter_value(k, QBITS);
    end

    assign quad   = idx[TABLE_BITS-1 -: 2];
    assign offset = idx[QBITS-1:0];
    // odd quadrants run the table backwards
    assign addr   = quad[0] ? ((QBITS+1)'(N) - {1'b0, offset}) : {1'b0, offset};
    assign mag    = rom[addr];

    always_comb
    begin
        if (quad[1])
        begin
            sample = -$signed({1'b0, mag});
        end
        else
        begin
            sample = $signed({1'b0, mag});
        end
    end
endmodule
`default_nettype wire

@@ sv/tspg_ctrl.sv @@
// Sample counter, period position and phase accumulator; registers one request per tick.
`default_nettype none
module tspg_ctrl #(
    parameter int unsigned PHASE_BITS = 32,
    parameter int unsigned TABLE_BITS = 10,
    parameter int unsigned COUNT_BITS = 24
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire tspg_pkg::cfg_t        cfg,
    input  wire logic                  in_valid,
    input  wire logic                  restart,
    input  wire logic                  advance,
    output logic                       in_stall,
    output tspg_pkg::req_t             req,
    output logic [TABLE_BITS-1:0]      req_idx
);
    localparam int unsigned TB = tspg_pkg::TOTAL_BITS;

    logic [TB-1:0]         count_reg;
    logic [TB-1:0]         count_next;
    logic [COUNT_BITS-1:0] pos_reg;
    logic [COUNT_BITS-1:0] pos_next;
    logic [PHASE_BITS-1:0] phase_reg;
    logic [PHASE_BITS-1:0] phase_next;
    tspg_pkg::req_t        req_reg;
    tspg_pkg::req_t        req_next;
    logic [TABLE_BITS-1:0] idx_reg;
    logic [TABLE_BITS-1:0] idx_next;

    logic                  take;
    logic                  accept;
    logic [TB-1:0]         cnt;
    logic [COUNT_BITS-1:0] pos;
    logic [PHASE_BITS-1:0] phase;
    logic [COUNT_BITS-1:0] per;
    logic [COUNT_BITS-1:0] pul;
    logic [COUNT_BITS:0]   pos_inc;
    logic                  produce;

    assign take     = !req_reg.valid || advance;
    assign in_stall = !take;
    assign accept   = in_valid && take;

    always_comb
    begin
        cnt        = restart ? '0 : count_reg;
        pos        = restart ? '0 : pos_reg;
        phase      = restart ? '0 : phase_reg;
        per        = COUNT_BITS'(cfg.period);
        pul        = COUNT_BITS'(cfg.pulse);
        produce    = cnt < cfg.total;
        count_next = cnt;
        pos_next   = pos;
        phase_next = phase;
        idx_next   = phase[PHASE_BITS-1 -: TABLE_BITS];
        req_next   = '0;
        pos_inc    = {1'b0, pos} + (COUNT_BITS+1)'(1);

        if (cfg.mode == tspg_pkg::MODE_PULSE && pul > per)
        begin
            per = pul;
        end
        if (per == '0)
        begin
            per = COUNT_BITS'(1);
        end

        if (produce)
        begin
            count_next     = cnt + TB'(1);
            req_next.valid = 1'b1;
            req_next.last  = (count_next == cfg.total);
            case (cfg.mode)
                tspg_pkg::MODE_IMPULSE, tspg_pkg::MODE_PULSE:
                begin
                    req_next.level = (cfg.mode == tspg_pkg::MODE_IMPULSE) ? (pos == '0)
                                                                         : (pos < pul);
                    // wrap once at or past the period end
                    pos_next = (pos_inc >= {1'b0, per}) ? '0 : pos_inc[COUNT_BITS-1:0];
                end
                tspg_pkg::MODE_SINE:
                begin
                    req_next.sine = 1'b1;
                    phase_next    = phase + PHASE_BITS'(cfg.step);
                end
                tspg_pkg::MODE_ONES:
                begin
                    req_next.level = 1'b1;
                end
                default:
                begin
                    req_next.level = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            pos_reg   <= '0;
            phase_reg <= '0;
            req_reg   <= '0;
        end
        else if (take)
        begin
            req_reg.valid <= accept && req_next.valid;
            if (accept)
            begin
                count_reg     <= count_next;
                pos_reg       <= pos_next;
                phase_reg     <= phase_next;
                req_reg.sine  <= req_next.sine;
                req_reg.level <= req_next.level;
                req_reg.last  <= req_next.last;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            idx_reg <= idx_next;
        end
    end

    assign req     = req_reg;
    assign req_idx = idx_reg;
endmodule
`default_nettype wire

@@ sv/test_signal_pattern_generator.sv @@
// Top level of the test signal pattern generator: config registers and output stage.
// Each request is registered in the counter stage, then its sample in the output stage.
// Throughput: one request per cycle; the counter stage and the output register each
// hold one request, and the input stalls only while both are full and out_stall is high.
// Reset: rst_n clears all config registers, counters and the phase; the sine table is
// constant logic, so no clearing pass is needed and requests are taken right after reset.
`default_nettype none
module test_signal_pattern_generator #(
    parameter int unsigned PHASE_BITS      = 32,
    parameter int unsigned SINE_TABLE_BITS = 10,
    parameter int unsigned COUNT_BITS      = 24
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire logic                                   restart,
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic signed [tspg_pkg::SAMPLE_BITS-1:0]     i_sample,
    output logic signed [tspg_pkg::SAMPLE_BITS-1:0]     q_sample,
    output logic                                        last,
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [tspg_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  wire logic [tspg_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
    localparam int unsigned SW = tspg_pkg::SAMPLE_BITS;
    localparam int unsigned N  = 1 << (SINE_TABLE_BITS - 2);

    tspg_pkg::cfg_t                 cfg_reg;
    tspg_pkg::req_t                 req;
    logic [SINE_TABLE_BITS-1:0]     req_idx;
    logic [SINE_TABLE_BITS-1:0]     cos_idx;
    logic signed [SW-1:0]           sin_val;
    logic signed [SW-1:0]           cos_val;
    logic signed [SW-1:0]           level_val;
    logic                           advance;
    logic                           out_valid_reg;
    logic signed [SW-1:0]           i_sample_reg;
    logic signed [SW-1:0]           q_sample_reg;
    logic                           last_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                tspg_pkg::REG_MODE:   cfg_reg.mode   <= tspg_pkg::mode_t'(cfg_data[1:0]);
                tspg_pkg::REG_TOTAL:  cfg_reg.total  <= cfg_data[tspg_pkg::TOTAL_BITS-1:0];
                tspg_pkg::REG_PERIOD: cfg_reg.period <= cfg_data[tspg_pkg::LEN_BITS-1:0];
                tspg_pkg::REG_PULSE:  cfg_reg.pulse  <= cfg_data[tspg_pkg::LEN_BITS-1:0];
                tspg_pkg::REG_STEP:   cfg_reg.step   <= cfg_data[tspg_pkg::STEP_BITS-1:0];
                default:              cfg_reg        <= cfg_reg;
            endcase
        end
    end

    // the output register frees up when empty or when the sink takes it
    assign advance = !out_valid_reg || !out_stall;

    tspg_ctrl #(
        .PHASE_BITS (PHASE_BITS),
        .TABLE_BITS (SINE_TABLE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (in_valid),
        .restart  (restart),
        .advance  (advance),
        .in_stall (in_stall),
        .req      (req),
        .req_idx  (req_idx)
    );

    // cos leads sin by a quarter turn
    assign cos_idx = req_idx + SINE_TABLE_BITS'(N);

    tspg_sine #(.TABLE_BITS(SINE_TABLE_BITS)) u_sin (
        .idx    (req_idx),
        .sample (sin_val)
    );

    tspg_sine #(.TABLE_BITS(SINE_TABLE_BITS)) u_cos (
        .idx    (cos_idx),
        .sample (cos_val)
    );

    assign level_val = req.level ? $signed({1'b0, tspg_pkg::FULL_SCALE}) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && req.valid)
        begin
            i_sample_reg <= req.sine ? cos_val : level_val;
            q_sample_reg <= req.sine ? sin_val : level_val;
            last_reg     <= req.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign i_sample  = i_sample_reg;
    assign q_sample  = q_sample_reg;
    assign last      = last_reg;
endmodule
`default_nettype wire
